// ===== hdl/scc_pkg.sv =====
// Shared constants and types for the strongly connected component size engine.
package scc_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 4096;
	localparam int TOP_COUNT    = 5;

	localparam int VW    = 11;                    // vertex number / size width
	localparam int EW    = 13;                    // edge count / adjacency offset width
	localparam int EAW   = $clog2(MAX_EDGES);     // edge store address
	localparam int VDEPTH = MAX_VERTICES + 2;     // per-vertex tables, vertices 0..n+1
	localparam int VAW   = $clog2(VDEPTH);
	localparam int SAW   = $clog2(MAX_VERTICES);  // stack and finish order address
	localparam int RW    = 3;

	typedef struct packed {
		logic [VW-1:0] edge_tail;
		logic [VW-1:0] edge_head;
		logic          last_edge;
	} edge_t;

	typedef struct packed {
		logic [RW-1:0] rank;
		logic [VW-1:0] component_size;
		logic          last_result;
	} result_t;

	typedef struct packed {
		logic [VW-1:0] vtx;
		logic [EW-1:0] cur;
		logic [EW-1:0] stop;
	} stk_ent_t;

endpackage

// ===== hdl/scc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/scc_kosaraju_top_sizes.sv =====
// Kosaraju strongly connected components: edge loading, two graph walks, top sizes.
// Edges are taken one per cycle while stall is low, and the first 4096 are stored.
// The edge flagged last starts the computation, during which stall stays high.
// Each pass first clears all 1026 entries of the per-vertex tables. It then
// builds the adjacency lists: it counts the stored edges per vertex, forms a
// prefix over n+1 vertices and places each edge; an edge with an end of 0 or
// above n is ignored. The walk reads the target of each traversed edge and
// its mark. Each vertex needs the root scan, the two adjacency reads and the
// pop. Pass one walks the reversed graph and records the finish order; pass
// two takes roots in reverse finish order. The adjacency and mark memories
// each have one read port and one write port. Five size transfers follow,
// largest first, zero padded; then new edges are taken.
module scc_kosaraju_top_sizes (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    edge_valid,
	output logic                    edge_stall,
	input  scc_pkg::edge_t          edge_data,
	output logic                    result_valid,
	input  logic                    result_stall,
	output scc_pkg::result_t        result,
	input  logic                    vertex_count_we,
	input  logic [scc_pkg::VW-1:0]  vertex_count
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CLR    = 5'd1;
	localparam logic [4:0] S_ERD    = 5'd2;
	localparam logic [4:0] S_ECNT   = 5'd3;
	localparam logic [4:0] S_EINC   = 5'd4;
	localparam logic [4:0] S_PFX    = 5'd5;
	localparam logic [4:0] S_PFXW   = 5'd6;
	localparam logic [4:0] S_PLRD   = 5'd7;
	localparam logic [4:0] S_PLCNT  = 5'd8;
	localparam logic [4:0] S_PLW    = 5'd9;
	localparam logic [4:0] S_P1ROOT = 5'd10;
	localparam logic [4:0] S_P2ROOT = 5'd11;
	localparam logic [4:0] S_P2FIN  = 5'd12;
	localparam logic [4:0] S_RMARK  = 5'd13;
	localparam logic [4:0] S_STEP   = 5'd14;
	localparam logic [4:0] S_TGT    = 5'd15;
	localparam logic [4:0] S_MARK   = 5'd16;
	localparam logic [4:0] S_ADJ0   = 5'd17;
	localparam logic [4:0] S_ADJ1   = 5'd18;
	localparam logic [4:0] S_POPRD  = 5'd19;
	localparam logic [4:0] S_OUT    = 5'd20;

	logic [4:0]               state_q;
	logic [scc_pkg::VW-1:0]   vc_q, n_q;
	logic [scc_pkg::EW-1:0]   edges_q, idx_q, total_q, st_q;
	logic                     pass2_q;
	logic [scc_pkg::VW-1:0]   from_q, to_q, root_q, k_q, fin_cnt_q, w_q, depth_q, tree_q;
	scc_pkg::stk_ent_t        tos_q;
	logic [scc_pkg::VW-1:0]   top_q [scc_pkg::TOP_COUNT];
	logic [scc_pkg::RW-1:0]   rank_q;

	// memory ports
	logic                     es_we;
	logic [scc_pkg::EAW-1:0]  es_waddr, es_raddr;
	logic [scc_pkg::VW-1:0]   esrc_rd, edst_rd;
	logic                     adj_we;
	logic [scc_pkg::VAW-1:0]  adj_waddr, adj_raddr;
	logic [scc_pkg::EW-1:0]   adj_wdata, adj_rd;
	logic                     mk_we, mk_wdata, mark_rd;
	logic [scc_pkg::VAW-1:0]  mk_waddr, mk_raddr;
	logic                     tg_we;
	logic [scc_pkg::EAW-1:0]  tg_waddr, tg_raddr;
	logic [scc_pkg::VW-1:0]   tgt_rd;
	logic                     fn_we;
	logic [scc_pkg::SAW-1:0]  fn_waddr, fn_raddr;
	logic [scc_pkg::VW-1:0]   fin_rd;
	logic                     sk_we;
	logic [scc_pkg::SAW-1:0]  sk_waddr, sk_raddr;
	scc_pkg::stk_ent_t        stk_rd;

	logic                     edge_xfer, result_xfer, edge_ok, has_next, pop_last;
	logic [scc_pkg::VW-1:0]   e_from, e_to, n_act, tree_sz;
	logic [scc_pkg::EW-1:0]   adj_dec;
	logic [scc_pkg::VW-1:0]   top_ins [scc_pkg::TOP_COUNT];

	assign edge_stall   = state_q != S_IDLE;
	assign result_valid = state_q == S_OUT;
	assign edge_xfer    = edge_valid && !edge_stall;
	assign result_xfer  = result_valid && !result_stall;

	assign result.rank           = rank_q;
	assign result.component_size = top_q[0];
	assign result.last_result    = rank_q == scc_pkg::RW'(scc_pkg::TOP_COUNT);

	assign n_act = (vc_q == '0) ? scc_pkg::VW'(1) :
		(vc_q > scc_pkg::VW'(scc_pkg::MAX_VERTICES)) ? scc_pkg::VW'(scc_pkg::MAX_VERTICES) : vc_q;

	// pass one walks the reversed graph
	assign edge_ok = (esrc_rd != '0) && (esrc_rd <= n_q) && (edst_rd != '0) && (edst_rd <= n_q);
	assign e_from  = pass2_q ? esrc_rd : edst_rd;
	assign e_to    = pass2_q ? edst_rd : esrc_rd;
	assign adj_dec = adj_rd - scc_pkg::EW'(1);

	assign has_next = tos_q.cur < tos_q.stop;
	assign pop_last = depth_q == scc_pkg::VW'(1);
	assign tree_sz  = tree_q + scc_pkg::VW'(1);

	always_comb begin
		top_ins[0] = (tree_sz > top_q[0]) ? tree_sz : top_q[0];
		for (int i = 1; i < scc_pkg::TOP_COUNT; i++) begin
			if (tree_sz > top_q[i]) begin
				top_ins[i] = (tree_sz <= top_q[i-1]) ? tree_sz : top_q[i-1];
			end else begin
				top_ins[i] = top_q[i];
			end
		end
	end

	always_comb begin
		es_we     = edge_xfer && (edges_q < scc_pkg::EW'(scc_pkg::MAX_EDGES));
		es_waddr  = edges_q[scc_pkg::EAW-1:0];
		es_raddr  = idx_q[scc_pkg::EAW-1:0];
		adj_we    = 1'b0;
		adj_waddr = idx_q[scc_pkg::VAW-1:0];
		adj_wdata = '0;
		adj_raddr = idx_q[scc_pkg::VAW-1:0];
		mk_we     = 1'b0;
		mk_waddr  = w_q;
		mk_wdata  = 1'b1;
		mk_raddr  = w_q;
		tg_we     = 1'b0;
		tg_waddr  = adj_dec[scc_pkg::EAW-1:0];
		tg_raddr  = tos_q.cur[scc_pkg::EAW-1:0];
		fn_we     = 1'b0;
		fn_waddr  = fin_cnt_q[scc_pkg::SAW-1:0];
		fn_raddr  = k_q[scc_pkg::SAW-1:0] - scc_pkg::SAW'(1);
		sk_we     = 1'b0;
		sk_waddr  = depth_q[scc_pkg::SAW-1:0] - scc_pkg::SAW'(1);
		sk_raddr  = depth_q[scc_pkg::SAW-1:0] - scc_pkg::SAW'(2);
		case (state_q)
			S_CLR: begin
				adj_we   = 1'b1;
				mk_we    = 1'b1;
				mk_waddr = idx_q[scc_pkg::VAW-1:0];
				mk_wdata = 1'b0;
			end
			S_ECNT, S_PLCNT: begin
				adj_raddr = e_from;
			end
			S_EINC: begin
				adj_we    = 1'b1;
				adj_waddr = from_q;
				adj_wdata = adj_rd + scc_pkg::EW'(1);
			end
			S_PFXW: begin
				adj_we    = 1'b1;
				adj_wdata = total_q + adj_rd;
			end
			S_PLW: begin
				adj_we    = 1'b1;
				adj_waddr = from_q;
				adj_wdata = adj_dec;
				tg_we     = 1'b1;
			end
			S_P1ROOT: begin
				mk_raddr = root_q;
			end
			S_P2FIN: begin
				mk_raddr = fin_rd;
			end
			S_TGT: begin
				mk_raddr = tgt_rd;
			end
			S_RMARK: begin
				mk_we     = !mark_rd;
				adj_raddr = w_q;
			end
			S_MARK: begin
				mk_we     = !mark_rd;
				sk_we     = !mark_rd;
				adj_raddr = w_q;
			end
			S_ADJ0: begin
				adj_raddr = w_q + scc_pkg::VW'(1);
			end
			S_STEP: begin
				fn_we = !has_next && !pass2_q;
			end
			default: begin
			end
		endcase
	end

	scc_ram #(.WIDTH(scc_pkg::VW), .DEPTH(scc_pkg::MAX_EDGES)) u_esrc (
		.clk(clk), .we(es_we), .waddr(es_waddr), .wdata(edge_data.edge_tail),
		.raddr(es_raddr), .rdata(esrc_rd)
	);

	scc_ram #(.WIDTH(scc_pkg::VW), .DEPTH(scc_pkg::MAX_EDGES)) u_edst (
		.clk(clk), .we(es_we), .waddr(es_waddr), .wdata(edge_data.edge_head),
		.raddr(es_raddr), .rdata(edst_rd)
	);

	scc_ram #(.WIDTH(scc_pkg::EW), .DEPTH(scc_pkg::VDEPTH)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rd)
	);

	scc_ram #(.WIDTH(1), .DEPTH(scc_pkg::VDEPTH)) u_mark (
		.clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.raddr(mk_raddr), .rdata(mark_rd)
	);

	scc_ram #(.WIDTH(scc_pkg::VW), .DEPTH(scc_pkg::MAX_EDGES)) u_tgt (
		.clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(to_q),
		.raddr(tg_raddr), .rdata(tgt_rd)
	);

	scc_ram #(.WIDTH(scc_pkg::VW), .DEPTH(scc_pkg::MAX_VERTICES)) u_fin (
		.clk(clk), .we(fn_we), .waddr(fn_waddr), .wdata(tos_q.vtx),
		.raddr(fn_raddr), .rdata(fin_rd)
	);

	scc_ram #(.WIDTH($bits(scc_pkg::stk_ent_t)), .DEPTH(scc_pkg::MAX_VERTICES)) u_stk (
		.clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(tos_q),
		.raddr(sk_raddr), .rdata(stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vc_q      <= scc_pkg::VW'(scc_pkg::MAX_VERTICES);
			edges_q   <= '0;
			pass2_q   <= 1'b0;
			fin_cnt_q <= '0;
			depth_q   <= '0;
			rank_q    <= '0;
		end else begin
			if (vertex_count_we) begin
				vc_q <= vertex_count;
			end
			case (state_q)
				S_IDLE: begin
					if (edge_xfer) begin
						if (es_we) begin
							edges_q <= edges_q + scc_pkg::EW'(1);
						end
						if (edge_data.last_edge) begin
							n_q     <= n_act;
							pass2_q <= 1'b0;
							idx_q   <= '0;
							for (int i = 0; i < scc_pkg::TOP_COUNT; i++) begin
								top_q[i] <= '0;
							end
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					if (idx_q == scc_pkg::EW'(scc_pkg::VDEPTH - 1)) begin
						idx_q   <= '0;
						state_q <= S_ERD;
					end else begin
						idx_q <= idx_q + scc_pkg::EW'(1);
					end
				end
				S_ERD: begin
					if (idx_q == edges_q) begin
						idx_q   <= scc_pkg::EW'(1);
						total_q <= '0;
						state_q <= S_PFX;
					end else begin
						state_q <= S_ECNT;
					end
				end
				S_ECNT: begin
					from_q <= e_from;
					if (edge_ok) begin
						state_q <= S_EINC;
					end else begin
						idx_q   <= idx_q + scc_pkg::EW'(1);
						state_q <= S_ERD;
					end
				end
				S_EINC: begin
					idx_q   <= idx_q + scc_pkg::EW'(1);
					state_q <= S_ERD;
				end
				S_PFX: begin
					state_q <= S_PFXW;
				end
				S_PFXW: begin
					total_q <= total_q + adj_rd;
					if (idx_q == scc_pkg::EW'(n_q) + scc_pkg::EW'(1)) begin
						idx_q   <= '0;
						state_q <= S_PLRD;
					end else begin
						idx_q   <= idx_q + scc_pkg::EW'(1);
						state_q <= S_PFX;
					end
				end
				S_PLRD: begin
					if (idx_q == edges_q) begin
						if (pass2_q) begin
							k_q     <= fin_cnt_q;
							state_q <= S_P2ROOT;
						end else begin
							root_q    <= n_q;
							fin_cnt_q <= '0;
							state_q   <= S_P1ROOT;
						end
					end else begin
						state_q <= S_PLCNT;
					end
				end
				S_PLCNT: begin
					from_q <= e_from;
					to_q   <= e_to;
					if (edge_ok) begin
						state_q <= S_PLW;
					end else begin
						idx_q   <= idx_q + scc_pkg::EW'(1);
						state_q <= S_PLRD;
					end
				end
				S_PLW: begin
					idx_q   <= idx_q + scc_pkg::EW'(1);
					state_q <= S_PLRD;
				end
				S_P1ROOT: begin
					if (root_q == '0) begin
						pass2_q <= 1'b1;
						idx_q   <= '0;
						state_q <= S_CLR;
					end else begin
						w_q     <= root_q;
						root_q  <= root_q - scc_pkg::VW'(1);
						state_q <= S_RMARK;
					end
				end
				S_P2ROOT: begin
					if (k_q == '0) begin
						rank_q  <= scc_pkg::RW'(1);
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q - scc_pkg::VW'(1);
						state_q <= S_P2FIN;
					end
				end
				S_P2FIN: begin
					w_q     <= fin_rd;
					state_q <= S_RMARK;
				end
				S_RMARK: begin
					if (mark_rd) begin
						state_q <= pass2_q ? S_P2ROOT : S_P1ROOT;
					end else begin
						depth_q <= '0;
						tree_q  <= '0;
						state_q <= S_ADJ0;
					end
				end
				S_MARK: begin
					state_q <= mark_rd ? S_STEP : S_ADJ0;
				end
				S_ADJ0: begin
					st_q    <= adj_rd;
					state_q <= S_ADJ1;
				end
				S_ADJ1: begin
					tos_q.vtx  <= w_q;
					tos_q.cur  <= st_q;
					tos_q.stop <= adj_rd;
					depth_q    <= depth_q + scc_pkg::VW'(1);
					state_q    <= S_STEP;
				end
				S_STEP: begin
					if (has_next) begin
						tos_q.cur <= tos_q.cur + scc_pkg::EW'(1);
						state_q   <= S_TGT;
					end else begin
						tree_q  <= tree_sz;
						depth_q <= depth_q - scc_pkg::VW'(1);
						if (!pass2_q) begin
							fin_cnt_q <= fin_cnt_q + scc_pkg::VW'(1);
						end
						if (pop_last) begin
							if (pass2_q) begin
								for (int i = 0; i < scc_pkg::TOP_COUNT; i++) begin
									top_q[i] <= top_ins[i];
								end
								state_q <= S_P2ROOT;
							end else begin
								state_q <= S_P1ROOT;
							end
						end else begin
							state_q <= S_POPRD;
						end
					end
				end
				S_TGT: begin
					w_q     <= tgt_rd;
					state_q <= S_MARK;
				end
				S_POPRD: begin
					tos_q   <= stk_rd;
					state_q <= S_STEP;
				end
				S_OUT: begin
					if (result_xfer) begin
						for (int i = 0; i < scc_pkg::TOP_COUNT - 1; i++) begin
							top_q[i] <= top_q[i+1];
						end
						top_q[scc_pkg::TOP_COUNT-1] <= '0;
						rank_q <= rank_q + scc_pkg::RW'(1);
						if (result.last_result) begin
							edges_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/scc_kosaraju_top_sizes_tb.sv =====
// Testbench for the Kosaraju component size engine: edge lists in, top five sizes checked.
module scc_kosaraju_top_sizes_tb;

	localparam int STALL_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic edge_valid;
	logic edge_stall;
	scc_pkg::edge_t edge_data;
	logic result_valid;
	logic result_stall;
	scc_pkg::result_t result;
	logic vertex_count_we;
	logic [scc_pkg::VW-1:0] vertex_count;

	scc_kosaraju_top_sizes u_top (
		.clk(clk),
		.arst_n(arst_n),
		.edge_valid(edge_valid),
		.edge_stall(edge_stall),
		.edge_data(edge_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.vertex_count_we(vertex_count_we),
		.vertex_count(vertex_count)
	);

	// predictor state
	int unsigned vcount_cfg;
	int unsigned tails[$];
	int unsigned heads[$];
	scc_pkg::result_t sizes_expected[$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit hold_recv;
	int unsigned errors;
	int unsigned edges_sent;
	int unsigned results_seen;
	int unsigned graphs_done;
	int unsigned quiet_cycles;

	typedef struct {
		int unsigned tail;
		int unsigned head;
		bit last;
		int unsigned top_size; // 0 means use predictor
	} stim_row_t;

	stim_row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Kosaraju on stored edges; a DFS from each unvisited root in each pass, iterative with edge cursors
	function automatic void predict_sizes();
		int unsigned n;
		int unsigned adj_start[];
		int unsigned adj_to[];
		int unsigned fill[];
		bit seen[];
		int unsigned order[$];
		int unsigned leader[];
		int unsigned cnt[];
		int unsigned stk_v[$];
		int unsigned stk_c[$];
		int unsigned top[scc_pkg::TOP_COUNT];
		int unsigned total;
		int unsigned e_cnt;
		int unsigned a;
		int unsigned b;
		int unsigned s;
		int j;
		scc_pkg::result_t r;
		n = vcount_cfg;
		if (n < 1) n = 1;
		if (n > scc_pkg::MAX_VERTICES) n = scc_pkg::MAX_VERTICES;
		e_cnt = tails.size();
		adj_start = new[n + 2];
		fill = new[n + 2];
		adj_to = new[e_cnt + 1];
		seen = new[n + 1];
		leader = new[n + 1];
		cnt = new[n + 1];
		for (int pass = 0; pass < 2; pass++) begin
			foreach (adj_start[i]) adj_start[i] = 0;
			for (int e = 0; e < e_cnt; e++) begin
				a = tails[e];
				b = heads[e];
				if (a >= 1 && a <= n && b >= 1 && b <= n)
					adj_start[pass == 0 ? b : a]++;
			end
			total = 0;
			for (int v = 0; v <= n + 1; v++) begin
				s = adj_start[v];
				adj_start[v] = total;
				fill[v] = total;
				total += s;
			end
			for (int e = 0; e < e_cnt; e++) begin
				a = tails[e];
				b = heads[e];
				if (a >= 1 && a <= n && b >= 1 && b <= n) begin
					if (pass == 0) begin
						adj_to[fill[b]] = a;
						fill[b]++;
					end else begin
						adj_to[fill[a]] = b;
						fill[a]++;
					end
				end
			end
			foreach (seen[i]) seen[i] = 0;
			for (int k = 0; k < n; k++) begin
				int unsigned root;
				if (pass == 0) root = n - k;
				else root = order[n - 1 - k];
				if (!seen[root]) begin
					seen[root] = 1;
					leader[root] = root;
					stk_v.push_back(root);
					stk_c.push_back(adj_start[root]);
					while (stk_v.size() > 0) begin
						int unsigned v;
						int unsigned c;
						v = stk_v[$];
						c = stk_c[$];
						if (c < adj_start[v + 1]) begin
							stk_c[$] = c + 1;
							if (!seen[adj_to[c]]) begin
								seen[adj_to[c]] = 1;
								leader[adj_to[c]] = root;
								stk_v.push_back(adj_to[c]);
								stk_c.push_back(adj_start[adj_to[c]]);
							end
						end else begin
							void'(stk_v.pop_back());
							void'(stk_c.pop_back());
							if (pass == 0) order.push_back(v);
						end
					end
				end
			end
		end
		foreach (cnt[i]) cnt[i] = 0;
		for (int v = 1; v <= n; v++) cnt[leader[v]]++;
		foreach (top[i]) top[i] = 0;
		for (int v = 1; v <= n; v++) begin
			s = cnt[v];
			if (s != 0 && s > top[scc_pkg::TOP_COUNT - 1]) begin
				j = scc_pkg::TOP_COUNT - 1;
				while (j > 0 && top[j - 1] < s) begin
					top[j] = top[j - 1];
					j--;
				end
				top[j] = s;
			end
		end
		for (int k = 0; k < scc_pkg::TOP_COUNT; k++) begin
			r.rank = scc_pkg::RW'(k + 1);
			r.component_size = scc_pkg::VW'(top[k]);
			r.last_result = (k == scc_pkg::TOP_COUNT - 1);
			sizes_expected.push_back(r);
		end
		tails.delete();
		heads.delete();
	endfunction

	task automatic send_edge(input int unsigned tail, input int unsigned head, input bit last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			edge_valid <= 1'b0;
			@(posedge clk);
		end
		edge_valid <= 1'b1;
		edge_data.edge_tail <= scc_pkg::VW'(tail);
		edge_data.edge_head <= scc_pkg::VW'(head);
		edge_data.last_edge <= last;
		do @(posedge clk); while (edge_stall);
		if (tails.size() < scc_pkg::MAX_EDGES) begin
			tails.push_back(tail & 11'h7FF);
			heads.push_back(head & 11'h7FF);
		end
		edges_sent++;
		if (last) begin
			predict_sizes();
			graphs_done++;
		end
	endtask

	// directed table: typed largest size checked where given
	task automatic walk_rows();
		int unsigned got;
		foreach (rows[i]) begin
			send_edge(rows[i].tail, rows[i].head, rows[i].last);
			if (rows[i].top_size != 0) begin
				got = sizes_expected[sizes_expected.size() - scc_pkg::TOP_COUNT].component_size;
				if (got != rows[i].top_size) begin
					$display("%0t directed row %0d expected top %0d actual %0d", $time, i,
						rows[i].top_size, got);
					errors++;
				end
			end
		end
	endtask

	task automatic drain_and_set(input int unsigned value);
		edge_valid <= 1'b0;
		while (sizes_expected.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		vertex_count_we <= 1'b1;
		vertex_count <= scc_pkg::VW'(value);
		@(posedge clk);
		vertex_count_we <= 1'b0;
		vcount_cfg = value;
	endtask

	// random graph: ring edges, random in-range edges and out-of-range noise edges
	task automatic send_graph(input int unsigned n, input int unsigned edges);
		int unsigned t;
		int unsigned h;
		for (int i = 0; i < edges; i++) begin
			case ($urandom_range(9))
				0: begin
					t = $urandom_range(2047);
					h = $urandom_range(2047);
				end
				1, 2, 3, 4: begin
					t = $urandom_range(n, 1);
					h = (t % n) + 1;
				end
				default: begin
					t = $urandom_range(n, 1);
					h = $urandom_range(n, 1);
				end
			endcase
			send_edge(t, h, i == edges - 1);
		end
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= hold_recv ||
				(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// checker
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (sizes_expected.size() == 0) begin
				$display("%0t unexpected result rank %0d size %0d", $time,
					result.rank, result.component_size);
				errors++;
			end else begin
				scc_pkg::result_t x;
				x = sizes_expected.pop_front();
				if (result !== x) begin
					$display("%0t mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
						x.rank, x.component_size, x.last_result,
						result.rank, result.component_size, result.last_result);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((edge_valid && !edge_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		edge_valid = 1'b0;
		edge_data = '0;
		vertex_count_we = 1'b0;
		vertex_count = '0;
		hold_recv = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 71;
		errors = 0;
		edges_sent = 0;
		results_seen = 0;
		graphs_done = 0;
		quiet_cycles = 0;
		vcount_cfg = 1024;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset default 1024 vertices, self loop only: all singletons
		rows = '{'{1, 1, 1, 1}};
		walk_rows();

		drain_and_set(0);
		rows = '{'{1, 1, 1, 1}};
		walk_rows();
		drain_and_set(5);
		rows = '{
			'{1, 2, 0, 0}, '{2, 3, 0, 0}, '{3, 1, 0, 0}, '{4, 5, 0, 0},
			'{0, 3, 0, 0}, '{6, 1, 0, 0}, '{2047, 2047, 0, 0}, '{5, 4, 1, 3},
			'{1, 2, 1, 1},
			'{5, 4, 0, 0}, '{4, 3, 0, 0}, '{3, 2, 0, 0}, '{2, 1, 0, 0}, '{1, 5, 1, 5}
		};
		walk_rows();
		drain_and_set(1024);
		send_edge(1024, 1, 0);
		send_edge(1, 1024, 1);
		drain_and_set(2047);
		send_edge(1024, 1024, 1);

		drain_and_set(12);
		repeat (12) send_graph(12, $urandom_range(20, 2));

		// long receiver hold while edges keep coming
		hold_recv <= 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_recv <= 1'b0;
			end
			begin
				send_graph(12, 6);
				send_graph(12, 6);
			end
		join

		send_idle_pct = 71;
		recv_idle_pct = 14;
		drain_and_set(30);
		repeat (8) send_graph(30, $urandom_range(30, 5));
		drain_and_set(7);
		repeat (6) send_graph(7, $urandom_range(12, 1));

		send_idle_pct = 0;
		recv_idle_pct = 0;
		drain_and_set(20);
		repeat (6) send_graph(20, $urandom_range(25, 3));
		drain_and_set(1);
		send_graph(1, 3);

		edge_valid <= 1'b0;
		while (sizes_expected.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d edges in %0d graphs, checked %0d size results.",
			edges_sent, graphs_done, results_seen);
		$display("Vertex counts from 0 to 2047 and idle mixes on both sides were used.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
